@@ rtl/residency_percent_tracker_defines.svh @@
// Assertion helpers used by the residency percent tracker RTL.
`ifndef RESIDENCY_PERCENT_TRACKER_DEFINES_SVH
`define RESIDENCY_PERCENT_TRACKER_DEFINES_SVH

// Check that an expression holds at every clock edge outside reset.
`define RPT_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define RPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/rpt_pkg.sv @@
// ----------------------------------------------------------------------------
// rpt_pkg
// Types, constants and helpers for the residency percent tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rpt_pkg;

  localparam int SLOT_W      = 4;
  localparam int TS_W        = 64;
  localparam int CNT_W       = 64;
  localparam int BITS_W      = 7;
  localparam int RES_W       = 61;
  localparam int FREQ_W      = 40;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 40;
  localparam int K_W         = 20;
  localparam int DCNT_W      = 7;
  localparam int NUM_SLOTS_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_LEGACY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ   = 1'd1;

  localparam logic [K_W-1:0]    K_LEGACY  = 20'd1000000;
  localparam logic [K_W-1:0]    K_SCALE   = 20'd100000;
  localparam logic [CNT_W-1:0]  DIFF_LIM  = 64'h0000_1000_0000_0000;
  localparam logic [CNT_W-1:0]  QUO_MAX   = 64'd18446744073709;
  localparam logic [FREQ_W-1:0] FREQ_RST  = 40'd1000000000;
  localparam logic [BITS_W-1:0] WIDTH_MAX = 7'd64;

  typedef struct packed {
    logic [TS_W-1:0]   tbase;
    logic [CNT_W-1:0]  cbase;
    logic [BITS_W-1:0] width;
    logic [RES_W-1:0]  held;
    logic              unk;
    logic              inv;
  } ent_t;

  typedef enum logic [2:0] {
    WR_OOB, WR_INIT, WR_RES, WR_INV, WR_BASE
  } wr_kind_t;

  typedef enum logic [1:0] {
    CD_HOLD, CD_MUL, CD_QUO, CD_SAT
  } cd_op_t;

  typedef enum logic {
    KS_LEGACY, KS_SCALE
  } k_sel_t;

  typedef enum logic {
    DS_FREQ, DS_TDIFF
  } d_sel_t;

  typedef struct packed {
    logic     load;
    logic     rd;
    logic     eval;
    logic     mul_start;
    k_sel_t   mul_k;
    logic     div_start;
    d_sel_t   div_d;
    cd_op_t   cd_op;
    logic     fin;
    wr_kind_t kind;
  } cmd_t;

  typedef struct packed {
    logic is_init;
    logic oob;
    logic legacy;
    logic cd_small;
    logic td_nz;
    logic quo_big;
    logic mul_busy;
    logic div_busy;
    logic out_block;
  } stat_t;

  function automatic logic [BITS_W-1:0] clamp_bits(input logic [BITS_W-1:0] b);
    logic [BITS_W-1:0] r;
    if (b == '0) begin
      r = 7'd1;
    end else if (b > WIDTH_MAX) begin
      r = WIDTH_MAX;
    end else begin
      r = b;
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] width_mask(input logic [BITS_W-1:0] w);
    logic [BITS_W-1:0] sh;
    sh = WIDTH_MAX - w;
    return {CNT_W{1'b1}} >> sh;
  endfunction

endpackage

`default_nettype wire

@@ rtl/rpt_in_if.sv @@
// ----------------------------------------------------------------------------
// rpt_in_if
// Input item channel: valid/ready handshake with init or update request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rpt_in_if;
  import rpt_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [SLOT_W-1:0] slot;
  logic [TS_W-1:0]   timestamp_sample;
  logic [CNT_W-1:0]  counter_sample;
  logic [BITS_W-1:0] counter_bits;

  modport source (
    output valid, req_type, slot, timestamp_sample, counter_sample, counter_bits,
    input  ready
  );

  modport sink (
    input  valid, req_type, slot, timestamp_sample, counter_sample, counter_bits,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/rpt_out_if.sv @@
// ----------------------------------------------------------------------------
// rpt_out_if
// Result item channel: valid/ready handshake with slot residency and flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rpt_out_if;
  import rpt_pkg::*;

  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] out_slot;
  logic [RES_W-1:0]  residency;
  logic              value_unknown;
  logic              value_invalid;
  logic              value_updated;

  modport source (
    output valid, out_slot, residency, value_unknown, value_invalid, value_updated,
    input  ready
  );

  modport sink (
    input  valid, out_slot, residency, value_unknown, value_invalid, value_updated,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/rpt_ram.sv @@
// ----------------------------------------------------------------------------
// rpt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]             wdata,
  input  wire logic                         re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/rpt_dp.sv @@
// ----------------------------------------------------------------------------
// rpt_dp
// Datapath: item registers, slot RAM, serial multiplier and divider, result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpt_dp #(
  parameter int NUM_SLOTS = rpt_pkg::NUM_SLOTS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_req_type,
  input  wire logic [rpt_pkg::SLOT_W-1:0]      in_slot,
  input  wire logic [rpt_pkg::TS_W-1:0]        in_ts,
  input  wire logic [rpt_pkg::CNT_W-1:0]       in_cnt,
  input  wire logic [rpt_pkg::BITS_W-1:0]      in_bits,
  input  wire logic                            cfg_we,
  input  wire logic [rpt_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [rpt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire rpt_pkg::cmd_t                   cmd,
  output      rpt_pkg::stat_t                  stat,
  output      logic                            out_valid,
  input  wire logic                            out_ready,
  output      logic [rpt_pkg::SLOT_W-1:0]      out_slot,
  output      logic [rpt_pkg::RES_W-1:0]       out_res,
  output      logic                            out_unk,
  output      logic                            out_inv,
  output      logic                            out_upd
);
  import rpt_pkg::*;

  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic                 req_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [TS_W-1:0]      ts_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [BITS_W-1:0]    bits_r;
  logic                 legacy_r;
  logic [FREQ_W-1:0]    freq_r;
  logic [NUM_SLOTS-1:0] vld_r;
  ent_t                 ent_r;
  logic [CNT_W-1:0]     c_r;
  logic [CNT_W-1:0]     cd_r;
  logic [TS_W-1:0]      td_r;
  logic [CNT_W-1:0]     acc_r;
  logic [CNT_W-1:0]     mcand_r;
  logic [K_W-1:0]       mk_r;
  logic [CNT_W-1:0]     rem_r;
  logic [CNT_W-1:0]     quo_r;
  logic [CNT_W-1:0]     dvs_r;
  logic [DCNT_W-1:0]    dcnt_r;
  logic                 out_valid_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic [RES_W-1:0]     out_res_r;
  logic                 out_unk_r;
  logic                 out_inv_r;
  logic                 out_upd_r;

  logic [AW-1:0]        addr;
  logic                 oob;
  logic                 ent_ok;
  ent_t                 rdata;
  ent_t                 ent_rd;
  logic [CNT_W-1:0]     m_rd;
  logic [CNT_W-1:0]     c_rd;
  ent_t                 ent_nxt;
  logic [BITS_W-1:0]    w_init;
  logic [CNT_W-1:0]     freq_eff;
  logic [CNT_W:0]       dsh;
  logic                 dge;
  logic                 wr_en;

  assign addr   = AW'(slot_r);
  assign oob    = !(32'(slot_r) < NUM_SLOTS);
  assign ent_ok = !oob && vld_r[addr];
  assign w_init = clamp_bits(bits_r);
  assign freq_eff = (freq_r == '0) ? 64'd1 : {{(CNT_W-FREQ_W){1'b0}}, freq_r};
  assign dsh    = {rem_r, quo_r[CNT_W-1]};
  assign dge    = dsh >= {1'b0, dvs_r};
  assign wr_en  = cmd.fin && (cmd.kind != WR_OOB);

  rpt_ram #(
    .WIDTH ($bits(ent_t)),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (addr),
    .wdata (ent_nxt),
    .re    (cmd.rd),
    .raddr (addr),
    .rdata (rdata)
  );

  always_comb begin
    ent_rd = rdata;
    if (!ent_ok) begin
      ent_rd.width = WIDTH_MAX;
      ent_rd.held  = '0;
      ent_rd.unk   = 1'b1;
      ent_rd.inv   = 1'b0;
    end
    m_rd = width_mask(ent_rd.width);
    c_rd = cnt_r & m_rd;
  end

  always_comb begin
    ent_nxt       = ent_r;
    ent_nxt.tbase = ts_r;
    ent_nxt.cbase = c_r;
    case (cmd.kind)
      WR_INIT: begin
        ent_nxt.width = w_init;
        ent_nxt.cbase = cnt_r & width_mask(w_init);
        ent_nxt.held  = '0;
        ent_nxt.unk   = 1'b1;
        ent_nxt.inv   = 1'b0;
      end
      WR_RES: begin
        ent_nxt.held = quo_r[RES_W-1:0];
        ent_nxt.unk  = 1'b0;
        ent_nxt.inv  = 1'b0;
      end
      WR_INV: begin
        ent_nxt.inv = 1'b1;
      end
      WR_OOB: begin
        ent_nxt.held = '0;
        ent_nxt.unk  = 1'b1;
        ent_nxt.inv  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat.is_init   = !req_r;
    stat.oob       = oob;
    stat.legacy    = legacy_r;
    stat.cd_small  = cd_r < DIFF_LIM;
    stat.td_nz     = td_r != '0;
    stat.quo_big   = quo_r > QUO_MAX;
    stat.mul_busy  = mk_r != '0;
    stat.div_busy  = dcnt_r != '0;
    stat.out_block = out_valid_r && !out_ready;
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= in_req_type;
      slot_r <= in_slot;
      ts_r   <= in_ts;
      cnt_r  <= in_cnt;
      bits_r <= in_bits;
    end
    if (cmd.eval) begin
      ent_r <= ent_rd;
      c_r   <= c_rd;
      cd_r  <= (c_rd - ent_rd.cbase) & m_rd;
      td_r  <= ts_r - ent_rd.tbase;
    end else begin
      case (cmd.cd_op)
        CD_MUL:  cd_r <= acc_r;
        CD_QUO:  cd_r <= quo_r;
        CD_SAT:  cd_r <= '1;
        default: begin
        end
      endcase
    end
    if (cmd.mul_start) begin
      acc_r   <= '0;
      mcand_r <= cd_r;
    end else if (mk_r != '0) begin
      if (mk_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r <= mcand_r << 1;
    end
    if (cmd.div_start) begin
      rem_r <= '0;
      quo_r <= cd_r;
      dvs_r <= (cmd.div_d == DS_FREQ) ? freq_eff : td_r;
    end else if (dcnt_r != '0) begin
      rem_r <= dge ? CNT_W'(dsh - {1'b0, dvs_r}) : dsh[CNT_W-1:0];
      quo_r <= {quo_r[CNT_W-2:0], dge};
    end
    if (cmd.fin) begin
      out_slot_r <= slot_r;
      out_res_r  <= ent_nxt.held;
      out_unk_r  <= ent_nxt.unk;
      out_inv_r  <= ent_nxt.inv;
      out_upd_r  <= cmd.kind == WR_RES;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      legacy_r    <= 1'b0;
      freq_r      <= FREQ_RST;
      vld_r       <= '0;
      mk_r        <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_LEGACY: legacy_r <= cfg_wdata[0];
          CFG_FREQ:   freq_r   <= cfg_wdata[FREQ_W-1:0];
          default: begin
          end
        endcase
      end
      if (wr_en) begin
        vld_r[addr] <= 1'b1;
      end
      if (cmd.mul_start) begin
        mk_r <= (cmd.mul_k == KS_LEGACY) ? K_LEGACY : K_SCALE;
      end else begin
        mk_r <= mk_r >> 1;
      end
      if (cmd.div_start) begin
        dcnt_r <= DCNT_W'(CNT_W);
      end else if (dcnt_r != '0) begin
        dcnt_r <= dcnt_r - 1'b1;
      end
      if (cmd.fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_slot  = out_slot_r;
  assign out_res   = out_res_r;
  assign out_unk   = out_unk_r;
  assign out_inv   = out_inv_r;
  assign out_upd   = out_upd_r;

endmodule

`default_nettype wire

@@ rtl/rpt_ctrl.sv @@
// ----------------------------------------------------------------------------
// rpt_ctrl
// Controller: sequences slot read, rescaling, residency division and write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "residency_percent_tracker_defines.svh"

module rpt_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output      logic           in_ready,
  input  wire rpt_pkg::stat_t stat,
  output      rpt_pkg::cmd_t  cmd
);
  import rpt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_EVAL, S_DISP, S_LMULW, S_LDIV, S_LDIVQW, S_LDIVW,
    S_QCHK, S_QMUL, S_QMULW, S_RCHK, S_RMULW, S_RDIV, S_RDIVW, S_DONE
  } state_t;

  state_t   state_r, state_nxt;
  wr_kind_t kind_r, kind_nxt;

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    cmd           = '0;
    cmd.mul_k     = KS_LEGACY;
    cmd.div_d     = DS_FREQ;
    cmd.cd_op     = CD_HOLD;
    cmd.kind      = kind_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = S_DISP;
      end
      S_DISP: begin
        if (stat.oob) begin
          kind_nxt  = WR_OOB;
          state_nxt = S_DONE;
        end else if (stat.is_init) begin
          kind_nxt  = WR_INIT;
          state_nxt = S_DONE;
        end else if (!stat.legacy) begin
          state_nxt = S_RCHK;
        end else if (stat.cd_small) begin
          cmd.mul_start = 1'b1;
          cmd.mul_k     = KS_LEGACY;
          state_nxt     = S_LMULW;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_d     = DS_FREQ;
          state_nxt     = S_LDIVW;
        end
      end
      S_LMULW: begin
        if (!stat.mul_busy) begin
          cmd.cd_op = CD_MUL;
          state_nxt = S_LDIV;
        end
      end
      S_LDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_d     = DS_FREQ;
        state_nxt     = S_LDIVQW;
      end
      S_LDIVQW: begin
        if (!stat.div_busy) begin
          cmd.cd_op = CD_QUO;
          state_nxt = S_RCHK;
        end
      end
      S_LDIVW: begin
        if (!stat.div_busy) begin
          state_nxt = S_QCHK;
        end
      end
      S_QCHK: begin
        if (stat.quo_big) begin
          cmd.cd_op = CD_SAT;
          state_nxt = S_RCHK;
        end else begin
          cmd.cd_op = CD_QUO;
          state_nxt = S_QMUL;
        end
      end
      S_QMUL: begin
        cmd.mul_start = 1'b1;
        cmd.mul_k     = KS_LEGACY;
        state_nxt     = S_QMULW;
      end
      S_QMULW: begin
        if (!stat.mul_busy) begin
          cmd.cd_op = CD_MUL;
          state_nxt = S_RCHK;
        end
      end
      S_RCHK: begin
        if (!stat.td_nz) begin
          kind_nxt  = WR_BASE;
          state_nxt = S_DONE;
        end else if (!stat.cd_small) begin
          kind_nxt  = WR_INV;
          state_nxt = S_DONE;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_k     = KS_SCALE;
          state_nxt     = S_RMULW;
        end
      end
      S_RMULW: begin
        if (!stat.mul_busy) begin
          cmd.cd_op = CD_MUL;
          state_nxt = S_RDIV;
        end
      end
      S_RDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_d     = DS_TDIFF;
        state_nxt     = S_RDIVW;
      end
      S_RDIVW: begin
        if (!stat.div_busy) begin
          kind_nxt  = WR_RES;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!stat.out_block) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= WR_OOB;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

  `RPT_ASSERT_ALWAYS(a_idle_units, (state_r != S_IDLE) || (!stat.mul_busy && !stat.div_busy), "arith unit busy while idle")
  `RPT_ASSERT_ALWAYS(a_one_unit, !(stat.mul_busy && stat.div_busy), "multiplier and divider busy together")
  `RPT_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready, "item accepted while one in flight")

endmodule

`default_nettype wire

@@ rtl/residency_percent_tracker.sv @@
// Residency percent tracker.
// Input channel in_ch carries init or update items for one of NUM_SLOTS slots;
// result channel out_ch returns one item per input item: the slot, its held
// residency in thousandths of a percent, and unknown/invalid/updated flags.
// Configuration writes on cfg_we/cfg_idx/cfg_wdata select legacy 1 MHz
// rescaling and the counter frequency; write them only while idle.
// One item is in flight at a time. Init and out-of-range items pass through
// the read, evaluate, dispatch and done states from accept to result; an update
// also runs the bit-serial divider (up to two divisions) and the shift-add
// constant multiplier (up to two multiplications) before its result.
// The result sits in an output register; a stalled receiver holds it and
// the next item's work runs until its own result would overwrite it.
// Synchronous reset clears all slots to unknown with zero residency and
// width 64 through per-slot valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
// residency_percent_tracker
// Top level: joins controller and datapath to the item channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module residency_percent_tracker #(
  parameter int NUM_SLOTS = rpt_pkg::NUM_SLOTS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  rpt_in_if.sink                              in_ch,
  rpt_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [rpt_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [rpt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rpt_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;
  logic  out_valid;

  rpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rpt_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req_type (in_ch.req_type),
    .in_slot     (in_ch.slot),
    .in_ts       (in_ch.timestamp_sample),
    .in_cnt      (in_ch.counter_sample),
    .in_bits     (in_ch.counter_bits),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ch.ready),
    .out_slot    (out_ch.out_slot),
    .out_res     (out_ch.residency),
    .out_unk     (out_ch.value_unknown),
    .out_inv     (out_ch.value_invalid),
    .out_upd     (out_ch.value_updated)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

`default_nettype wire

@@ verif/tb_residency_percent_tracker.sv @@
// ----------------------------------------------------------------------------
// tb_residency_percent_tracker
// Drives init and update items into the residency tracker under several
// register settings and idle patterns, predicts every result per slot, and
// compares each returned item field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_residency_percent_tracker;
  import rpt_pkg::*;

  localparam int DRAIN_CYCLES = 250;
  localparam int STALL_LIMIT  = 20000;
  localparam int HOLD_CYCLES  = 3000;
  localparam int PHASE_ITEMS  = 170;

  typedef struct {
    bit [3:0]  slot;
    bit [60:0] residency;
    bit        unknown;
    bit        invalid;
    bit        updated;
  } slot_result_t;

  function automatic bit [63:0] count_mask(bit [6:0] w);
    return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
  endfunction

  class residency_scoreboard;
    bit [63:0]    ts_base [16];
    bit [63:0]    cnt_base [16];
    bit [6:0]     cnt_width [16];
    bit [60:0]    held [16];
    bit           unk [16];
    bit           inv [16];
    bit           legacy;
    bit [39:0]    freq;
    slot_result_t pending_results [$];
    int           errors;

    function new();
      for (int i = 0; i < 16; i++) begin
        ts_base[i] = 0;
        cnt_base[i] = 0;
        cnt_width[i] = 64;
        held[i] = 0;
        unk[i] = 1;
        inv[i] = 0;
      end
      legacy = 0;
      freq = 40'd1000000000;
      errors = 0;
    endfunction

    function void note_item(bit req, bit [3:0] s, bit [63:0] ts, bit [63:0] cnt,
                            bit [6:0] bits);
      slot_result_t r;
      bit [63:0] m, c, td, cd, f, q;
      bit [6:0] w;
      r.slot = s;
      r.updated = 0;
      if (!req) begin
        w = (bits == 0) ? 7'd1 : ((bits > 64) ? 7'd64 : bits);
        cnt_width[s] = w;
        ts_base[s] = ts;
        cnt_base[s] = cnt & count_mask(w);
        held[s] = 0;
        unk[s] = 1;
        inv[s] = 0;
      end else begin
        m = count_mask(cnt_width[s]);
        c = cnt & m;
        td = ts - ts_base[s];
        cd = (c - cnt_base[s]) & m;
        ts_base[s] = ts;
        cnt_base[s] = c;
        if (legacy) begin
          f = (freq == 0) ? 64'd1 : 64'(freq);
          if (cd < (64'd1 << 44)) begin
            cd = (cd * 64'd1000000) / f;
          end else begin
            q = cd / f;
            cd = (q > (64'hFFFF_FFFF_FFFF_FFFF / 64'd1000000)) ? '1 : q * 64'd1000000;
          end
        end
        if (td != 0) begin
          if (cd < (64'd1 << 44)) begin
            held[s] = 61'((cd * 64'd100000) / td);
            unk[s] = 0;
            inv[s] = 0;
            r.updated = 1;
          end else begin
            inv[s] = 1;
          end
        end
      end
      r.residency = held[s];
      r.unknown = unk[s];
      r.invalid = inv[s];
      pending_results.push_back(r);
    endfunction

    function void check_result(slot_result_t a);
      slot_result_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result slot %0d res %0d", $time, a.slot, a.residency);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (a.slot !== e.slot) begin
        $display("%0t: out_slot exp %0d got %0d", $time, e.slot, a.slot);
        errors++;
      end
      if (a.residency !== e.residency) begin
        $display("%0t: residency slot %0d exp %0d got %0d", $time, e.slot,
                 e.residency, a.residency);
        errors++;
      end
      if (a.unknown !== e.unknown) begin
        $display("%0t: value_unknown slot %0d exp %0b got %0b", $time, e.slot,
                 e.unknown, a.unknown);
        errors++;
      end
      if (a.invalid !== e.invalid) begin
        $display("%0t: value_invalid slot %0d exp %0b got %0b", $time, e.slot,
                 e.invalid, a.invalid);
        errors++;
      end
      if (a.updated !== e.updated) begin
        $display("%0t: value_updated slot %0d exp %0b got %0b", $time, e.slot,
                 e.updated, a.updated);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rpt_in_if  in_ch ();
  rpt_out_if out_ch ();

  residency_percent_tracker uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  residency_scoreboard slot_track = new();

  int        tx_idle;
  int        rx_idle;
  bit        hold_req;
  int        hold_left;
  int        quiet_cycles;
  bit [63:0] gen_ts [16];
  bit [63:0] gen_cnt [16];
  bit [6:0]  gen_w [16];
  bit        gen_live [16];

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else begin
      out_ch.ready = ($urandom_range(99) >= rx_idle);
    end
  end

  always @(posedge clk) begin
    slot_result_t a;
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (out_ch.valid && out_ch.ready) begin
        a.slot = out_ch.out_slot;
        a.residency = out_ch.residency;
        a.unknown = out_ch.value_unknown;
        a.invalid = out_ch.value_invalid;
        a.updated = out_ch.value_updated;
        slot_track.check_result(a);
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_residency_percent_tracker: done, errors");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_LEGACY) slot_track.legacy = data[0];
    else slot_track.freq = data;
  endtask

  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (slot_track.pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_item(bit req, bit [3:0] s, bit [63:0] ts, bit [63:0] cnt,
                           bit [6:0] bits);
    while ($urandom_range(99) < tx_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.req_type = req;
    in_ch.slot = s;
    in_ch.timestamp_sample = ts;
    in_ch.counter_sample = cnt;
    in_ch.counter_bits = bits;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    slot_track.note_item(req, s, ts, cnt, bits);
    if (!req) begin
      gen_live[s] = 1;
      gen_w[s] = (bits == 0) ? 7'd1 : ((bits > 64) ? 7'd64 : bits);
      gen_cnt[s] = cnt & count_mask(gen_w[s]);
    end else begin
      gen_cnt[s] = cnt & count_mask(gen_w[s]);
    end
    gen_ts[s] = ts;
    @(negedge clk);
  endtask

  task automatic random_item();
    bit [3:0]  s;
    bit [63:0] td, cd, cnt, m;
    bit [6:0]  bits;
    s = 4'($urandom_range(15));
    if (!gen_live[s] || $urandom_range(11) == 0) begin
      case ($urandom_range(5))
        0: bits = 7'($urandom_range(127));
        1: bits = 7'($urandom_range(1, 8));
        default: bits = 7'($urandom_range(32, 64));
      endcase
      send_item(0, s, {$urandom, $urandom}, {$urandom, $urandom}, bits);
    end else if ($urandom_range(99) < 12) begin
      send_item(1, s, {$urandom, $urandom}, {$urandom, $urandom}, 7'($urandom));
    end else begin
      case ($urandom_range(9))
        0: td = 0;
        1: td = {$urandom, $urandom};
        2: td = 64'($urandom_range(1, 20));
        default: td = {32'd0, $urandom} << $urandom_range(0, 24) | 64'd1;
      endcase
      case ($urandom_range(9))
        0: cd = {$urandom, $urandom};
        1: cd = (64'd1 << 44) + $urandom_range(3) - 1;
        2: cd = 0;
        3: cd = td;
        default: cd = td >> $urandom_range(0, 16);
      endcase
      m = count_mask(gen_w[s]);
      cnt = (gen_cnt[s] + cd) & m;
      if ($urandom_range(3) == 0) cnt = cnt | ({$urandom, $urandom} & ~m);
      send_item(1, s, gen_ts[s] + td, cnt, 7'($urandom));
    end
  endtask

  initial begin
    bit [39:0] freq_set [7];
    bit        legacy_set [7];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_LEGACY;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.req_type = 1'b0;
    in_ch.slot = '0;
    in_ch.timestamp_sample = '0;
    in_ch.counter_sample = '0;
    in_ch.counter_bits = '0;
    out_ch.ready = 1'b0;
    tx_idle = 0;
    rx_idle = 0;
    hold_req = 0;
    hold_left = 0;
    quiet_cycles = 0;
    for (int i = 0; i < 16; i++) gen_live[i] = 0;
    legacy_set = '{0, 1, 1, 1, 1, 0, 1};
    freq_set = '{40'd1000000000, 40'd1000000000, 40'd1, 40'hFF_FFFF_FFFF, 40'd0,
                 40'd25000000, 40'd1000000};
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    write_reg(CFG_LEGACY, 0);
    write_reg(CFG_FREQ, 40'd1000000000);
    send_item(0, 0, 64'd0, '1, 7'd0);
    send_item(0, 1, 64'd0, 64'd0, 7'd64);
    send_item(0, 2, '1, '1, 7'd100);
    send_item(0, 3, 64'h8000_0000_0000_0000, 64'h1234, 7'd127);
    send_item(0, 4, 64'd100, 64'h80, 7'd7);
    send_item(0, 15, 64'd7, 64'd3, 7'd1);
    send_item(1, 0, 64'd10, 64'd0, 7'd0);
    send_item(1, 1, 64'd1000, 64'd500, 7'd0);
    send_item(1, 1, 64'd1000, 64'd600, 7'd0);
    send_item(1, 1, 64'd2000, 64'd600 + (64'd1 << 44), 7'd0);
    send_item(1, 1, 64'd3000, 64'd601 + (64'd1 << 44), 7'd0);
    send_item(1, 2, 64'd5, 64'd2, 7'd127);
    send_item(1, 2, 64'd5 + (64'd1 << 63), 64'd1 + (64'd1 << 44), 7'd0);
    send_item(1, 3, 64'h8000_0000_0000_0010, 64'h1238, 7'd0);
    send_item(1, 4, 64'd200, 64'hFFFF_FFFF_FFFF_FF05, 7'd0);
    send_item(1, 15, 64'd8, 64'd2, 7'd64);
    send_item(1, 15, 64'd10, '1, 7'd64);
    send_item(1, 0, '1, '1, 7'd64);

    for (int p = 0; p < 7; p++) begin
      wait_idle();
      write_reg(CFG_LEGACY, legacy_set[p]);
      write_reg(CFG_FREQ, freq_set[p]);
      case (p % 3)
        0: begin tx_idle = 38; rx_idle = 59; end
        1: begin tx_idle = 59; rx_idle = 38; end
        default: begin tx_idle = 0; rx_idle = 0; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == 40) hold_req = 1;
        random_item();
      end
    end

    wait_idle();
    if (slot_track.errors == 0 && slot_track.pending_results.size() == 0) begin
      $display("tb_residency_percent_tracker: done, clean");
    end else begin
      $display("tb_residency_percent_tracker: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/rpt_pkg.sv
rtl/rpt_in_if.sv
rtl/rpt_out_if.sv
rtl/rpt_ram.sv
rtl/rpt_dp.sv
rtl/rpt_ctrl.sv
rtl/residency_percent_tracker.sv
verif/tb_residency_percent_tracker.sv
